// ===== hw/rtl/lbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbcd_pkg
// Shared constants, result type and helpers of the label block decoder.
// ----------------------------------------------------------------------------
package lbcd_pkg;

    localparam int unsigned MAX_LABELS  = 4096;
    localparam int unsigned MAX_TABLE   = 8192;
    localparam int unsigned GRID_EDGE   = 8;
    localparam int unsigned NUM_SUB     = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int unsigned SUB_VOXELS  = 512;

    localparam int unsigned LBL_AW = $clog2(MAX_LABELS);
    localparam int unsigned TBL_AW = $clog2(MAX_TABLE);
    localparam int unsigned SUB_AW = $clog2(NUM_SUB);

    // result queue between decoder and output stage
    localparam int unsigned QDEPTH       = 16;
    localparam int unsigned QAW          = $clog2(QDEPTH);
    localparam int unsigned MAX_PER_BYTE = 8;

    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_UNIFORM = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_GRID  = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] label;
        logic [8:0]  subblock_number;
        logic [8:0]  voxel_offset;
        logic [9:0]  run_length;
        logic [2:0]  error_code;
        logic        block_done;
    } res_t;

    typedef struct packed {
        logic push;       // write one result at the tail
        logic discard;    // drop uncommitted results first
        logic commit;     // release everything written so far
        logic mark_done;  // flag the newest uncommitted result as last of block
    } qctl_t;

    // bits per packed voxel index for a subblock of ns labels (ns >= 2)
    function automatic logic [3:0] index_bits(input logic [9:0] ns);
        logic [3:0] b;
        if (ns <= 10'd2)        b = 4'd1;
        else if (ns <= 10'd4)   b = 4'd2;
        else if (ns <= 10'd8)   b = 4'd3;
        else if (ns <= 10'd16)  b = 4'd4;
        else if (ns <= 10'd32)  b = 4'd5;
        else if (ns <= 10'd64)  b = 4'd6;
        else if (ns <= 10'd128) b = 4'd7;
        else if (ns <= 10'd256) b = 4'd8;
        else                    b = 4'd9;
        return b;
    endfunction

endpackage

// ===== hw/rtl/label_block_compress_decode.sv =====
// ----------------------------------------------------------------------------
// label_block_compress_decode
// Decoder for compressed segmentation label blocks, one byte per beat.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one byte of the encoded block, s_tlast marks
// the final byte of the buffer. Output stream: one beat per result (voxel
// run, uniform block or format error); m_tuser is the result kind and m_tlast
// flags the last result of a block.
// Each voxel result that a byte unpacks passes the memory-port chain
// index -> local table -> global label -> queue, and the next byte is taken
// only when the last one is done. After the last count word and after each
// table word the subblock scan skips subblocks whose tables are full.
// Results are held in a 16-entry queue and released when their byte is done;
// a byte is taken only when 9 entries are free, so a stalled receiver stops
// intake without loss. A truncated block drops that byte's results and gives
// one truncation error. Reset returns the decoder to the header phase and
// empties the queue; the label and table stores need no clearing.
// ----------------------------------------------------------------------------
module label_block_compress_decode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // label, subblock_number, voxel_offset,
                                   // run_length, error_code, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // block_done
);

    lbcd_pkg::qctl_t qctl;
    lbcd_pkg::res_t  qres;
    lbcd_pkg::res_t  ores;
    logic            space_ok;

    lbcd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (space_ok),
        .qctl     (qctl),
        .qres     (qres)
    );

    lbcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qctl      (qctl),
        .qres      (qres),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (ores)
    );

    assign m_tdata = {1'b0, ores.error_code, ores.run_length, ores.voxel_offset,
                      ores.subblock_number, ores.label};
    assign m_tuser = ores.kind;
    assign m_tlast = ores.block_done;

endmodule

// ===== hw/rtl/lbcd_front.sv =====
// ----------------------------------------------------------------------------
// lbcd_front
// Byte intake, field assembly, label/table stores and voxel index unpacking.
// ----------------------------------------------------------------------------
module lbcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               space_ok,
    output lbcd_pkg::qctl_t    qctl,
    output lbcd_pkg::res_t     qres
);

    localparam logic [2:0] PH_HDR    = 3'd0;
    localparam logic [2:0] PH_LABELS = 3'd1;
    localparam logic [2:0] PH_COUNTS = 3'd2;
    localparam logic [2:0] PH_TABLES = 3'd3;
    localparam logic [2:0] PH_VOXELS = 3'd4;
    localparam logic [2:0] PH_IDLE   = 3'd5;

    localparam logic [3:0] S_WAIT     = 4'd0;
    localparam logic [3:0] S_BYTE     = 4'd1;
    localparam logic [3:0] S_SKIP_RD  = 4'd2;
    localparam logic [3:0] S_SKIP_CHK = 4'd3;
    localparam logic [3:0] S_VS_RD    = 4'd4;
    localparam logic [3:0] S_VS_CHK   = 4'd5;
    localparam logic [3:0] S_VX       = 4'd6;
    localparam logic [3:0] S_VX_L2G   = 4'd7;
    localparam logic [3:0] S_VX_GL    = 4'd8;
    localparam logic [3:0] S_VX_PUSH  = 4'd9;
    localparam logic [3:0] S_TBL_GL   = 4'd10;
    localparam logic [3:0] S_TBL_PUSH = 4'd11;
    localparam logic [3:0] S_END      = 4'd12;

    localparam int unsigned CB_W = 10 + lbcd_pkg::TBL_AW + 1;

    logic [3:0]  st_reg, st_next;
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [63:0] fasm_reg, fasm_next;
    logic [1:0]  hword_reg, hword_next;
    logic [12:0] ltot_reg, ltot_next;
    logic [13:0] tfill_reg, tfill_next;
    logic [9:0]  sc_reg, sc_next;
    logic [9:0]  vc_reg, vc_next;
    logic [15:0] pbits_reg, pbits_next;
    logic [4:0]  pcnt_reg, pcnt_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [9:0]  cur_cnt_reg, cur_cnt_next;
    logic [13:0] cur_base_reg, cur_base_next;
    logic [3:0]  nbits_reg, nbits_next;
    logic [lbcd_pkg::TBL_AW-1:0] e_reg, e_next;
    logic [lbcd_pkg::LBL_AW-1:0] w_reg, w_next;

    // stores
    logic [63:0]                 gl_mem  [lbcd_pkg::MAX_LABELS];
    logic [lbcd_pkg::LBL_AW-1:0] l2g_mem [lbcd_pkg::MAX_TABLE];
    logic [CB_W-1:0]             cb_mem  [lbcd_pkg::NUM_SUB];
    logic [63:0]                 gl_rd_reg;
    logic [lbcd_pkg::LBL_AW-1:0] l2g_rd_reg;
    logic [CB_W-1:0]             cb_rd_reg;
    logic [lbcd_pkg::LBL_AW-1:0] gl_raddr;
    logic                        gl_we, l2g_we, cb_we;
    logic [63:0]                 gl_wdata;
    logic [CB_W-1:0]             cb_wdata;
    logic [9:0]                  cb_cnt;
    logic [13:0]                 cb_base;

    logic        do_fail;
    logic [2:0]  fail_code;

    assign cb_cnt   = cb_rd_reg[CB_W-1 -: 10];
    assign cb_base  = cb_rd_reg[13:0];
    assign gl_raddr = (st_reg == S_TBL_GL) ? w_reg : l2g_rd_reg;
    assign in_ready = (st_reg == S_WAIT) && space_ok;

    always_ff @(posedge aclk) begin
        if (gl_we) begin
            gl_mem[tfill_reg[lbcd_pkg::LBL_AW-1:0]] <= gl_wdata;
        end
        gl_rd_reg <= gl_mem[gl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (l2g_we) begin
            l2g_mem[tfill_reg[lbcd_pkg::TBL_AW-1:0]] <= gl_wdata[lbcd_pkg::LBL_AW-1:0];
        end
        l2g_rd_reg <= l2g_mem[e_reg];
    end

    always_ff @(posedge aclk) begin
        if (cb_we) begin
            cb_mem[sc_reg[lbcd_pkg::SUB_AW-1:0]] <= cb_wdata;
        end
        cb_rd_reg <= cb_mem[sc_reg[lbcd_pkg::SUB_AW-1:0]];
    end

    always_comb begin
        logic [63:0] w;
        logic [3:0]  fcnt_inc;
        logic [3:0]  fwidth;
        logic [16:0] csum;
        logic [13:0] tfill_inc;
        logic [14:0] bsum;
        logic [4:0]  shamt;
        logic [15:0] shifted;
        logic [15:0] mask;
        logic [9:0]  idx;

        st_next       = st_reg;
        phase_next    = phase_reg;
        fcnt_next     = fcnt_reg;
        fasm_next     = fasm_reg;
        hword_next    = hword_reg;
        ltot_next     = ltot_reg;
        tfill_next    = tfill_reg;
        sc_next       = sc_reg;
        vc_next       = vc_reg;
        pbits_next    = pbits_reg;
        pcnt_next     = pcnt_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        cur_cnt_next  = cur_cnt_reg;
        cur_base_next = cur_base_reg;
        nbits_next    = nbits_reg;
        e_next        = e_reg;
        w_next        = w_reg;
        gl_we         = 1'b0;
        l2g_we        = 1'b0;
        cb_we         = 1'b0;
        do_fail       = 1'b0;
        fail_code     = lbcd_pkg::ERR_NONE;
        qctl          = '0;
        qres          = '0;

        w         = fasm_reg | (64'(byte_reg) << {fcnt_reg, 3'b000});
        fcnt_inc  = 4'(fcnt_reg) + 4'd1;
        tfill_inc = tfill_reg + 14'd1;
        csum      = 17'(tfill_reg) + 17'(w[15:0]);
        bsum      = 15'(cb_base) + 15'(cb_cnt);
        shamt     = pcnt_reg - 5'(nbits_reg);
        shifted   = pbits_reg >> shamt;
        mask      = (16'd1 << nbits_reg) - 16'd1;
        idx       = 10'(shifted & mask);
        gl_wdata  = w;
        cb_wdata  = {w[9:0], tfill_reg};

        unique case (phase_reg)
            PH_HDR:    fwidth = 4'd4;
            PH_LABELS: fwidth = 4'd8;
            PH_COUNTS: fwidth = 4'd2;
            default:   fwidth = 4'd4;
        endcase

        unique case (st_reg)
            S_WAIT: begin
                if (in_valid && space_ok) begin
                    byte_next = in_byte;
                    last_next = in_last;
                    st_next   = S_BYTE;
                end
            end
            S_BYTE: begin
                st_next = S_END;
                if (phase_reg == PH_VOXELS) begin
                    pbits_next = {pbits_reg[7:0], byte_reg};
                    pcnt_next  = pcnt_reg + 5'd8;
                    st_next    = S_VX;
                end else if (phase_reg != PH_IDLE) begin
                    if (fcnt_inc < fwidth) begin
                        fasm_next = w;
                        fcnt_next = fcnt_inc[2:0];
                    end else begin
                        fasm_next = '0;
                        fcnt_next = '0;
                        unique case (phase_reg)
                            PH_HDR: begin
                                if (hword_reg != 2'd3) begin
                                    if (w[31:0] != 32'(lbcd_pkg::GRID_EDGE)) begin
                                        do_fail   = 1'b1;
                                        fail_code = lbcd_pkg::ERR_BAD_GRID;
                                    end else begin
                                        hword_next = hword_reg + 2'd1;
                                    end
                                end else if (w[31:0] > 32'(lbcd_pkg::MAX_LABELS)) begin
                                    do_fail   = 1'b1;
                                    fail_code = lbcd_pkg::ERR_OVERFLOW;
                                end else begin
                                    ltot_next  = w[12:0];
                                    tfill_next = '0;
                                    sc_next    = '0;
                                    phase_next = (w[12:0] == 13'd0) ? PH_COUNTS : PH_LABELS;
                                end
                            end
                            PH_LABELS: begin
                                gl_we = 1'b1;
                                if (tfill_inc >= 14'(ltot_reg)) begin
                                    if (ltot_reg == 13'd1) begin
                                        qctl.push       = 1'b1;
                                        qres.kind       = lbcd_pkg::KIND_UNIFORM;
                                        qres.label      = w;
                                        qres.block_done = 1'b1;
                                        phase_next      = PH_IDLE;
                                    end else begin
                                        tfill_next = '0;
                                        sc_next    = '0;
                                        phase_next = PH_COUNTS;
                                    end
                                end else begin
                                    tfill_next = tfill_inc;
                                end
                            end
                            PH_COUNTS: begin
                                if (w[15:0] > 16'(lbcd_pkg::SUB_VOXELS) ||
                                    csum > 17'(lbcd_pkg::MAX_TABLE)) begin
                                    do_fail   = 1'b1;
                                    fail_code = lbcd_pkg::ERR_OVERFLOW;
                                end else begin
                                    cb_we      = 1'b1;
                                    tfill_next = csum[13:0];
                                    if (w[15:0] == 16'd0) begin
                                        qctl.push            = 1'b1;
                                        qres.kind            = lbcd_pkg::KIND_RUN;
                                        qres.subblock_number = sc_reg[8:0];
                                        qres.run_length      = 10'(lbcd_pkg::SUB_VOXELS);
                                    end
                                    if (sc_reg == 10'(lbcd_pkg::NUM_SUB - 1)) begin
                                        phase_next = PH_TABLES;
                                        tfill_next = '0;
                                        sc_next    = '0;
                                        st_next    = S_SKIP_RD;
                                    end else begin
                                        sc_next = sc_reg + 10'd1;
                                    end
                                end
                            end
                            default: begin
                                if (w >= 64'(ltot_reg) ||
                                    tfill_reg >= 14'(lbcd_pkg::MAX_TABLE)) begin
                                    do_fail   = 1'b1;
                                    fail_code = lbcd_pkg::ERR_RANGE;
                                end else begin
                                    l2g_we     = 1'b1;
                                    tfill_next = tfill_inc;
                                    if (cur_cnt_reg == 10'd1) begin
                                        w_next  = w[lbcd_pkg::LBL_AW-1:0];
                                        st_next = S_TBL_GL;
                                    end else begin
                                        st_next = S_SKIP_RD;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_TBL_GL: begin
                st_next = S_TBL_PUSH;
            end
            S_TBL_PUSH: begin
                qctl.push            = 1'b1;
                qres.kind            = lbcd_pkg::KIND_RUN;
                qres.label           = gl_rd_reg;
                qres.subblock_number = sc_reg[8:0];
                qres.run_length      = 10'(lbcd_pkg::SUB_VOXELS);
                st_next              = S_SKIP_RD;
            end
            S_SKIP_RD: begin
                if (sc_reg == 10'(lbcd_pkg::NUM_SUB)) begin
                    // every table is full: go unpack voxel indices
                    phase_next = PH_VOXELS;
                    sc_next    = '0;
                    vc_next    = '0;
                    pbits_next = '0;
                    pcnt_next  = '0;
                    st_next    = S_VS_RD;
                end else begin
                    st_next = S_SKIP_CHK;
                end
            end
            S_SKIP_CHK: begin
                if (15'(tfill_reg) >= bsum) begin
                    sc_next = sc_reg + 10'd1;
                    st_next = S_SKIP_RD;
                end else begin
                    cur_cnt_next = cb_cnt;
                    st_next      = S_END;
                end
            end
            S_VS_RD: begin
                if (sc_reg == 10'(lbcd_pkg::NUM_SUB)) begin
                    phase_next     = PH_IDLE;
                    qctl.mark_done = 1'b1;
                    st_next        = S_END;
                end else begin
                    st_next = S_VS_CHK;
                end
            end
            S_VS_CHK: begin
                if (cb_cnt < 10'd2) begin
                    sc_next = sc_reg + 10'd1;
                    st_next = S_VS_RD;
                end else begin
                    cur_cnt_next  = cb_cnt;
                    cur_base_next = cb_base;
                    nbits_next    = lbcd_pkg::index_bits(cb_cnt);
                    st_next       = S_END;
                end
            end
            S_VX: begin
                if (pcnt_reg < 5'(nbits_reg)) begin
                    st_next = S_END;
                end else begin
                    pcnt_next = shamt;
                    if (idx >= cur_cnt_reg) begin
                        do_fail   = 1'b1;
                        fail_code = lbcd_pkg::ERR_RANGE;
                    end else begin
                        e_next  = lbcd_pkg::TBL_AW'(cur_base_reg + 14'(idx));
                        st_next = S_VX_L2G;
                    end
                end
            end
            S_VX_L2G: begin
                st_next = S_VX_GL;
            end
            S_VX_GL: begin
                st_next = S_VX_PUSH;
            end
            S_VX_PUSH: begin
                qctl.push            = 1'b1;
                qres.kind            = lbcd_pkg::KIND_RUN;
                qres.label           = gl_rd_reg;
                qres.subblock_number = sc_reg[8:0];
                qres.voxel_offset    = vc_reg[8:0];
                qres.run_length      = 10'd1;
                if (vc_reg == 10'(lbcd_pkg::SUB_VOXELS - 1)) begin
                    sc_next    = sc_reg + 10'd1;
                    vc_next    = '0;
                    pbits_next = '0;
                    pcnt_next  = '0;
                    st_next    = S_VS_RD;
                end else begin
                    vc_next = vc_reg + 10'd1;
                    st_next = S_VX;
                end
            end
            S_END: begin
                qctl.commit = 1'b1;
                st_next     = S_WAIT;
                if (last_reg) begin
                    if (phase_reg != PH_IDLE) begin
                        // unfinished block: drop this byte's results, report truncation
                        qctl.discard         = 1'b1;
                        qctl.push            = 1'b1;
                        qres.kind            = lbcd_pkg::KIND_ERROR;
                        qres.subblock_number = sc_reg[8:0];
                        qres.voxel_offset    = vc_reg[8:0];
                        qres.error_code      = lbcd_pkg::ERR_TRUNCATED;
                        qres.block_done      = 1'b1;
                    end
                    phase_next = PH_HDR;
                    fcnt_next  = '0;
                    fasm_next  = '0;
                    hword_next = '0;
                    ltot_next  = '0;
                    tfill_next = '0;
                    sc_next    = '0;
                    vc_next    = '0;
                    pbits_next = '0;
                    pcnt_next  = '0;
                end
            end
            default: begin
                st_next = S_WAIT;
            end
        endcase

        if (do_fail) begin
            qctl.push            = 1'b1;
            qres                 = '0;
            qres.kind            = lbcd_pkg::KIND_ERROR;
            qres.subblock_number = sc_reg[8:0];
            qres.voxel_offset    = vc_reg[8:0];
            qres.error_code      = fail_code;
            qres.block_done      = 1'b1;
            phase_next           = PH_IDLE;
            st_next              = S_END;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_WAIT;
            phase_reg    <= PH_HDR;
            fcnt_reg     <= '0;
            fasm_reg     <= '0;
            hword_reg    <= '0;
            ltot_reg     <= '0;
            tfill_reg    <= '0;
            sc_reg       <= '0;
            vc_reg       <= '0;
            pbits_reg    <= '0;
            pcnt_reg     <= '0;
            last_reg     <= 1'b0;
            cur_cnt_reg  <= '0;
            cur_base_reg <= '0;
            nbits_reg    <= '0;
        end else begin
            st_reg       <= st_next;
            phase_reg    <= phase_next;
            fcnt_reg     <= fcnt_next;
            fasm_reg     <= fasm_next;
            hword_reg    <= hword_next;
            ltot_reg     <= ltot_next;
            tfill_reg    <= tfill_next;
            sc_reg       <= sc_next;
            vc_reg       <= vc_next;
            pbits_reg    <= pbits_next;
            pcnt_reg     <= pcnt_next;
            last_reg     <= last_next;
            cur_cnt_reg  <= cur_cnt_next;
            cur_base_reg <= cur_base_next;
            nbits_reg    <= nbits_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        e_reg    <= e_next;
        w_reg    <= w_next;
    end

endmodule

// ===== hw/rtl/lbcd_back.sv =====
// ----------------------------------------------------------------------------
// lbcd_back
// Commit queue for decoded results and the registered output stage.
// ----------------------------------------------------------------------------
module lbcd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  lbcd_pkg::qctl_t    qctl,
    input  lbcd_pkg::res_t     qres,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output lbcd_pkg::res_t     out_res
);

    localparam int unsigned PW = lbcd_pkg::QAW + 1;

    lbcd_pkg::res_t            q_mem [lbcd_pkg::QDEPTH];
    logic [lbcd_pkg::QDEPTH-1:0] done_reg, done_next;
    logic [PW-1:0]             wr_reg, wr_next;
    logic [PW-1:0]             rd_reg, rd_next;
    logic [PW-1:0]             cm_reg, cm_next;
    logic [PW-1:0]             wbase;
    logic [PW-1:0]             used;
    logic                      pop;
    logic                      ov_reg, ov_next;
    lbcd_pkg::res_t            or_reg;

    assign used     = wr_reg - rd_reg;
    assign space_ok = used <= PW'(lbcd_pkg::QDEPTH - lbcd_pkg::MAX_PER_BYTE - 1);
    assign wbase    = qctl.discard ? cm_reg : wr_reg;
    assign pop      = (rd_reg != cm_reg) && (!ov_reg || out_ready);

    always_comb begin
        wr_next   = wbase + PW'(qctl.push);
        cm_next   = qctl.commit ? wr_next : cm_reg;
        rd_next   = rd_reg + PW'(pop);
        ov_next   = pop ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
        done_next = done_reg;
        if (qctl.push) begin
            done_next[wbase[lbcd_pkg::QAW-1:0]] = qres.block_done;
        end
        if (qctl.mark_done && wr_reg != cm_reg) begin
            done_next[lbcd_pkg::QAW'(wr_reg - PW'(1))] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (qctl.push) begin
            q_mem[wbase[lbcd_pkg::QAW-1:0]] <= qres;
        end
        if (pop) begin
            or_reg            <= q_mem[rd_reg[lbcd_pkg::QAW-1:0]];
            or_reg.block_done <= done_reg[rd_reg[lbcd_pkg::QAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cm_reg   <= '0;
            ov_reg   <= 1'b0;
            done_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            cm_reg   <= cm_next;
            ov_reg   <= ov_next;
            done_reg <= done_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = or_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= PW'(lbcd_pkg::QDEPTH))
        else $error("result queue over full");

    a_commit_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        PW'(cm_reg - rd_reg) <= used)
        else $error("commit pointer outside queued range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        qctl.push && !qctl.discard |-> used < PW'(lbcd_pkg::QDEPTH))
        else $error("push into full result queue");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the label block decoder: directed header cases, then
// random encoded blocks (valid, uniform, empty-label, malformed, truncated)
// checked beat by beat against a behavioral decoder with random idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lbcd_pkg::*;

    localparam int PH_HDR = 0, PH_LABELS = 1, PH_COUNTS = 2, PH_TABLES = 3, PH_VOXELS = 4,
                   PH_IDLE = 5;

    typedef enum int {
        SEQ_VALID, SEQ_UNIFORM, SEQ_NO_LABELS, SEQ_BIG_N, SEQ_BIG_NS, SEQ_TABLE_OVF,
        SEQ_BAD_ENTRY, SEQ_BAD_INDEX, SEQ_BAD_GRID, SEQ_NOISE
    } seq_kind_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] err;
    } drow_t;

    typedef struct {
        logic typed;
        res_t res;
    } beat_tag_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    label_block_compress_decode DUT (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------- behavioral decoder ----------------
    int          phase, field_bytes, hdr_word, label_cnt, fill, sub_cur, vox_cur;
    int          bit_pool, bit_cnt;
    logic [63:0] field_word;
    logic [63:0] label_mem [MAX_LABELS];
    int          sub_count [NUM_SUB];
    int          sub_base  [NUM_SUB];
    int          local_map [MAX_TABLE];
    res_t        byte_results [$];
    res_t        expected_results [$];
    beat_tag_t   beat_tags [$];

    function automatic void push_result(logic [1:0] k, logic [63:0] lab, int sb, int vox,
                                        int run, logic [2:0] err);
        res_t r;
        if (byte_results.size() >= MAX_PER_BYTE) return;
        r.kind = k;
        r.label = lab;
        r.subblock_number = sb[8:0];
        r.voxel_offset = vox[8:0];
        r.run_length = run[9:0];
        r.error_code = err;
        r.block_done = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void abort_block(logic [2:0] err);
        push_result(KIND_ERROR, '0, sub_cur, vox_cur, 0, err);
        byte_results[byte_results.size()-1].block_done = 1'b1;
        phase = PH_IDLE;
    endfunction

    function automatic void close_block();
        if (byte_results.size() > 0) byte_results[byte_results.size()-1].block_done = 1'b1;
        phase = PH_IDLE;
    endfunction

    function automatic void clear_decoder();
        phase = PH_HDR;
        field_bytes = 0;
        field_word = '0;
        hdr_word = 0;
        label_cnt = 0;
        fill = 0;
        sub_cur = 0;
        vox_cur = 0;
        bit_pool = 0;
        bit_cnt = 0;
    endfunction

    function automatic void seek_voxel_sub();
        while (sub_cur < NUM_SUB && sub_count[sub_cur] < 2) sub_cur++;
        vox_cur = 0;
        bit_pool = 0;
        bit_cnt = 0;
        if (sub_cur >= NUM_SUB) close_block();
    endfunction

    function automatic void skip_full_tables();
        while (sub_cur < NUM_SUB && fill >= sub_base[sub_cur] + sub_count[sub_cur]) sub_cur++;
        if (sub_cur >= NUM_SUB) begin
            phase = PH_VOXELS;
            sub_cur = 0;
            seek_voxel_sub();
        end
    endfunction

    function automatic int width_of(int ns);
        int b = 0;
        while (b < 16 && (1 << b) < ns) b++;
        return b;
    endfunction

    function automatic void finish_field(logic [63:0] w);
        int c;
        case (phase)
            PH_HDR: begin
                if (hdr_word < 3) begin
                    if (w != 64'(GRID_EDGE)) begin
                        abort_block(ERR_BAD_GRID);
                        return;
                    end
                    hdr_word++;
                    return;
                end
                if (w > 64'(MAX_LABELS)) begin
                    abort_block(ERR_OVERFLOW);
                    return;
                end
                label_cnt = int'(w);
                fill = 0;
                sub_cur = 0;
                phase = (label_cnt == 0) ? PH_COUNTS : PH_LABELS;
            end
            PH_LABELS: begin
                if (fill < MAX_LABELS) label_mem[fill] = w;
                fill++;
                if (fill >= label_cnt) begin
                    if (label_cnt == 1) begin
                        push_result(KIND_UNIFORM, label_mem[0], 0, 0, 0, ERR_NONE);
                        close_block();
                        return;
                    end
                    fill = 0;
                    sub_cur = 0;
                    phase = PH_COUNTS;
                end
            end
            PH_COUNTS: begin
                c = int'(w[31:0]);
                if (sub_cur >= NUM_SUB || c > SUB_VOXELS || fill + c > MAX_TABLE) begin
                    abort_block(ERR_OVERFLOW);
                    return;
                end
                sub_count[sub_cur] = c;
                sub_base[sub_cur] = fill;
                fill += c;
                if (c == 0) push_result(KIND_RUN, '0, sub_cur, 0, SUB_VOXELS, ERR_NONE);
                sub_cur++;
                if (sub_cur >= NUM_SUB) begin
                    phase = PH_TABLES;
                    fill = 0;
                    sub_cur = 0;
                    skip_full_tables();
                end
            end
            PH_TABLES: begin
                if (w >= 64'(label_cnt) || fill >= MAX_TABLE || sub_cur >= NUM_SUB) begin
                    abort_block(ERR_RANGE);
                    return;
                end
                local_map[fill] = int'(w);
                if (sub_count[sub_cur] == 1)
                    push_result(KIND_RUN, label_mem[int'(w)], sub_cur, 0, SUB_VOXELS, ERR_NONE);
                fill++;
                skip_full_tables();
            end
            default: ;
        endcase
    endfunction

    function automatic void unpack_voxels(logic [7:0] d);
        int ns, b, idx, g;
        bit_pool = ((bit_pool << 8) | int'(d)) & 'hFFFF;
        bit_cnt += 8;
        while (phase == PH_VOXELS && sub_cur < NUM_SUB) begin
            ns = sub_count[sub_cur];
            b = width_of(ns);
            if (b == 0 || b > 9 || bit_cnt < b) return;
            idx = (bit_pool >> (bit_cnt - b)) & ((1 << b) - 1);
            bit_cnt -= b;
            if (idx >= ns) begin
                abort_block(ERR_RANGE);
                return;
            end
            g = local_map[sub_base[sub_cur] + idx];
            push_result(KIND_RUN, label_mem[g], sub_cur, vox_cur, 1, ERR_NONE);
            vox_cur++;
            if (vox_cur >= SUB_VOXELS) begin
                sub_cur++;
                seek_voxel_sub();
            end
        end
    endfunction

    function automatic void decode_byte(logic [7:0] d, logic last);
        int w;
        byte_results.delete();
        if (phase == PH_VOXELS) begin
            unpack_voxels(d);
        end else if (phase != PH_IDLE) begin
            w = (phase == PH_HDR) ? 4 : (phase == PH_LABELS) ? 8 : (phase == PH_COUNTS) ? 2 : 4;
            field_word |= 64'(d) << ((field_bytes & 7) * 8);
            field_bytes++;
            if (field_bytes >= w) begin
                logic [63:0] done_word;
                done_word = field_word;
                field_bytes = 0;
                field_word = '0;
                finish_field(done_word);
            end
        end
        if (last) begin
            if (phase != PH_IDLE) begin
                byte_results.delete();
                abort_block(ERR_TRUNCATED);
            end
            clear_decoder();
        end
    endfunction

    // ---------------- monitor and scoreboard ----------------
    int bytes_taken = 0, results_seen = 0, mismatches = 0, blocks_sent = 0;
    res_t got;

    always_comb begin
        got.label = m_tdata[63:0];
        got.subblock_number = m_tdata[72:64];
        got.voxel_offset = m_tdata[81:73];
        got.run_length = m_tdata[91:82];
        got.error_code = m_tdata[94:92];
        got.kind = m_tuser;
        got.block_done = m_tlast;
    end

    always @(posedge aclk) begin
        beat_tag_t tag;
        res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                tag = beat_tags.pop_front();
                decode_byte(s_tdata, s_tlast);
                if (tag.typed) begin
                    if (byte_results.size() != 1 || byte_results[0] !== tag.res)
                        $display("directed row: decoder disagrees with typed result");
                    expected_results.push_back(tag.res);
                end else begin
                    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
                end
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.label !== want.label ||
                        got.subblock_number !== want.subblock_number ||
                        got.voxel_offset !== want.voxel_offset ||
                        got.run_length !== want.run_length ||
                        got.error_code !== want.error_code ||
                        got.block_done !== want.block_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d\n  exp %p\n  got %p", mismatches, want, got);
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------
    bit calm = 0;
    bit hold_request = 0;

    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (700) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // ---------------- sender ----------------
    logic [7:0] stream_bytes [$];
    int         voxel_start;

    task automatic send_byte(logic [7:0] d, logic last, logic typed = 1'b0,
                             logic [2:0] err = ERR_NONE);
        beat_tag_t tag;
        tag.typed = typed;
        tag.res = '0;
        tag.res.kind = KIND_ERROR;
        tag.res.error_code = err;
        tag.res.block_done = 1'b1;
        beat_tags.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    function automatic void put_word(logic [63:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++) stream_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [63:0] pick_label();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    bit wide_done = 0;

    // encoded block; for bad_index one subblock gets a voxel index equal to its count
    function automatic void build_block(seq_kind_e kind);
        int n, sel, bad_sub, nvox, bad_pos;
        int counts [NUM_SUB];
        logic bits [$];
        stream_bytes.delete();
        voxel_start = -1;
        for (int g = 0; g < 3; g++)
            put_word((kind == SEQ_BAD_GRID && g == 2) ? 64'($urandom_range(0, 7)) : 64'(GRID_EDGE),
                     4);
        if (kind == SEQ_BAD_GRID) return;
        if (kind == SEQ_BIG_N) begin
            put_word($urandom_range(0, 1) ? 64'h0000_1001 : 64'hFFFF_FFFF, 4);
            return;
        end
        n = (kind == SEQ_NO_LABELS) ? 0 : (kind == SEQ_UNIFORM) ? 1 : $urandom_range(2, 12);
        put_word(64'(n), 4);
        for (int i = 0; i < n; i++) put_word(pick_label(), 8);
        if (n == 1) return;
        nvox = 0;
        bad_sub = $urandom_range(0, NUM_SUB - 1);
        for (int s = 0; s < NUM_SUB; s++) begin
            sel = $urandom_range(0, 99);
            if (n == 0) counts[s] = (sel < 2) ? 1 : 0;
            else if (kind == SEQ_BAD_INDEX && s == bad_sub) counts[s] = 3;
            else if (sel < 70) counts[s] = 0;
            else if (sel < 98 || nvox >= 2) counts[s] = 1;
            else if (!wide_done && $urandom_range(0, 3) == 0) counts[s] = SUB_VOXELS;
            else counts[s] = $urandom_range(2, 17);
            if (counts[s] == SUB_VOXELS) wide_done = 1;
            if (counts[s] >= 2) nvox++;
            if (kind == SEQ_TABLE_OVF) counts[s] = SUB_VOXELS;
            if (kind == SEQ_BIG_NS && s == bad_sub) begin
                put_word($urandom_range(0, 1) ? 64'hFFFF : 64'($urandom_range(513, 4000)), 2);
                return;
            end
            put_word(64'(counts[s]), 2);
            if (kind == SEQ_TABLE_OVF && s == 16) return;
        end
        for (int s = 0; s < NUM_SUB; s++)
            for (int j = 0; j < counts[s]; j++)
                put_word((kind == SEQ_BAD_ENTRY && $urandom_range(0, 99) == 0) ?
                         ($urandom_range(0, 1) ? 64'hFFFF_FFFF : 64'(n + $urandom_range(0, 9))) :
                         64'($urandom_range(0, n - 1)), 4);
        voxel_start = stream_bytes.size();
        for (int s = 0; s < NUM_SUB; s++) begin
            int b;
            if (counts[s] < 2) continue;
            b = width_of(counts[s]);
            bad_pos = (kind == SEQ_BAD_INDEX && s == bad_sub) ? $urandom_range(0, 511) : -1;
            bits.delete();
            for (int v = 0; v < SUB_VOXELS; v++) begin
                int idx;
                idx = (v == bad_pos) ? counts[s] : $urandom_range(0, counts[s] - 1);
                for (int k = b - 1; k >= 0; k--) bits.push_back(idx[k]);
            end
            for (int i = 0; i < bits.size(); i += 8)
                stream_bytes.push_back({bits[i], bits[i+1], bits[i+2], bits[i+3],
                                        bits[i+4], bits[i+5], bits[i+6], bits[i+7]});
        end
    endfunction

    task automatic send_stream(bit pressure);
        int len;
        len = stream_bytes.size();
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        else if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) begin
                stream_bytes.push_back($urandom());
                len++;
            end
        for (int i = 0; i < len; i++) begin
            if (pressure && i == voxel_start) hold_request = 1;
            send_byte(stream_bytes[i], i == len - 1);
        end
        blocks_sent++;
    endtask

    drow_t directed [] = '{
        '{8'h08, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 0, 0, ERR_NONE}, '{8'h07, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 0, 1, ERR_BAD_GRID},   // second grid word is 7
        '{8'hFF, 1, 0, ERR_NONE},       // ignored after the error, closes the buffer
        '{8'h00, 1, 1, ERR_TRUNCATED},  // single-byte buffer
        '{8'h08, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 0, 0, ERR_NONE}, '{8'hFF, 0, 0, ERR_NONE}, '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 0, 0, ERR_NONE},
        '{8'h00, 1, 1, ERR_BAD_GRID},   // error on the final byte wins over truncation
        '{8'h80, 1, 1, ERR_TRUNCATED}
    };

    seq_kind_e plan [] = '{SEQ_VALID, SEQ_UNIFORM, SEQ_BIG_N, SEQ_NO_LABELS, SEQ_BAD_GRID,
                           SEQ_BIG_NS, SEQ_TABLE_OVF, SEQ_BAD_ENTRY, SEQ_BAD_INDEX,
                           SEQ_NOISE, SEQ_VALID, SEQ_UNIFORM};

    initial begin
        int drain;
        clear_decoder();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_byte(directed[i].data, directed[i].last,
                                        directed[i].typed, directed[i].err);
        foreach (plan[p]) begin
            if (plan[p] == SEQ_NOISE) begin
                stream_bytes.delete();
                repeat ($urandom_range(1, 30)) stream_bytes.push_back($urandom());
                voxel_start = -1;
            end else begin
                build_block(plan[p]);
            end
            send_stream(p == 0);
        end
        calm = 1;
        for (int r = 0; r < 3; r++) begin
            build_block($urandom_range(0, 1) ? SEQ_VALID : SEQ_UNIFORM);
            send_stream(0);
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (100) @(posedge aclk);
        if (expected_results.size() != 0) mismatches++;
        $display("run: %0d bytes in %0d buffers, %0d results checked", bytes_taken,
                 blocks_sent + 4, results_seen);
        $display("covered header errors, uniform, empty-label, overflow, table and index errors");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("timeout");
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lbcd_pkg.sv
hw/rtl/lbcd_front.sv
hw/rtl/lbcd_back.sv
hw/rtl/label_block_compress_decode.sv
tb/sv/testbench.sv
